[sv/crse_pkg.sv]
package crse_pkg;

    // Coordinate and parameter formats
    localparam int COORD_W = 32;
    localparam int FRAC_W  = 16;
    localparam int PARAM_W = FRAC_W + 1;

    // Working width of the lane datapath: covers 3 * 2a and the partial sums
    localparam int ACC_W  = COORD_W + 8;
    localparam int PROD_W = ACC_W + PARAM_W;

    // Register stages inside one lane, and accept-to-strobe latency of the block
    localparam int LANE_DEPTH = 7;
    localparam int RESULT_LAT = LANE_DEPTH + 1;

    localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(1) << FRAC_W;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic        [ACC_W-1:0]   mag_t;
    typedef logic        [PROD_W-1:0]  prod_t;
    typedef logic        [PARAM_W-1:0] param_t;

    typedef struct packed {
        acc_t point;
        acc_t slope;
    } lane_res_t;

    function automatic mag_t mag_of(input acc_t x);
        mag_t m;
        m = x[ACC_W-1] ? mag_t'(-x) : mag_t'(x);
        return m;
    endfunction

    // Round a magnitude product to nearest, ties away from zero, then restore the sign
    function automatic acc_t round_mul(input prod_t p, input logic neg, input int sh);
        prod_t r;
        mag_t  m;
        r = (p + (prod_t'(1) << (sh - 1))) >> sh;
        m = mag_t'(r);
        return neg ? -acc_t'(m) : acc_t'(m);
    endfunction

    function automatic acc_t half_round(input acc_t x);
        mag_t m;
        m = mag_of(x);
        m = (m + mag_t'(1)) >> 1;
        return x[ACC_W-1] ? -acc_t'(m) : acc_t'(m);
    endfunction

endpackage

[sv/catmull_rom_spline_eval.sv]
// done is high once the accepted word has passed every lane stage register and the merge register.
// Throughput: one word per cycle; busy stays low, every lane stage is a plain register.
// The receiver cannot stall: each result shows for exactly one cycle under done.
// Reset (rst_n, asynchronous, active low) clears the valid pipeline and done;
// words in flight at reset are dropped.
module catmull_rom_spline_eval (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  crse_pkg::coord_t p0_x,
    input  crse_pkg::coord_t p0_y,
    input  crse_pkg::coord_t p1_x,
    input  crse_pkg::coord_t p1_y,
    input  crse_pkg::coord_t p2_x,
    input  crse_pkg::coord_t p2_y,
    input  crse_pkg::coord_t p3_x,
    input  crse_pkg::coord_t p3_y,
    input  crse_pkg::param_t t_param,
    output logic             done,
    output crse_pkg::coord_t point_x,
    output crse_pkg::coord_t point_y,
    output crse_pkg::coord_t slope_x,
    output crse_pkg::coord_t slope_y,
    output logic             clamped
);
    import crse_pkg::*;

    // One lane per axis. Each lane runs the Horner form of the cubic and of its
    // derivative side by side:
    //   stage 1   coefficients 2a, 3*2a, 2b, 2c from the four coordinates
    //   stage 2-3 first multiply by s, round, add 2b (point) / 2*2b (slope)
    //   stage 4-5 second multiply by s, round, add 2c
    //   stage 6-7 point: last multiply by s/2, round, add v1; slope: halve
    // The merge stage clamps all four values to the coordinate range and
    // combines the out-of-range flags into clamped.

    param_t                t_sat;
    logic                  accept;
    logic [LANE_DEPTH-1:0] vld_next, vld_reg;
    lane_res_t             res_x, res_y;

    // Fully pipelined: a new word can enter every cycle.
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Saturate the parameter at 1.0
    assign t_sat = (t_param > PARAM_ONE) ? PARAM_ONE : t_param;

    // Track which lane stages hold a live word; the lanes themselves carry no valid.
    always_comb
    begin
        vld_next = {vld_reg[LANE_DEPTH-2:0], accept};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    crse_lane u_lane_x (
        .clk (clk),
        .v0  (p0_x),
        .v1  (p1_x),
        .v2  (p2_x),
        .v3  (p3_x),
        .t   (t_sat),
        .res (res_x)
    );

    crse_lane u_lane_y (
        .clk (clk),
        .v0  (p0_y),
        .v1  (p1_y),
        .v2  (p2_y),
        .v3  (p3_y),
        .t   (t_sat),
        .res (res_y)
    );

    crse_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (vld_reg[LANE_DEPTH-1]),
        .lane_x   (res_x),
        .lane_y   (res_y),
        .done     (done),
        .point_x  (point_x),
        .point_y  (point_y),
        .slope_x  (slope_x),
        .slope_y  (slope_y),
        .clamped  (clamped)
    );

endmodule

[sv/crse_lane.sv]
module crse_lane (
    input  logic                clk,
    input  crse_pkg::coord_t    v0,
    input  crse_pkg::coord_t    v1,
    input  crse_pkg::coord_t    v2,
    input  crse_pkg::coord_t    v3,
    input  crse_pkg::param_t    t,
    output crse_pkg::lane_res_t res
);
    import crse_pkg::*;

    acc_t   v0e, v1e, v2e, v3e, d12;

    // stage 1: coefficients
    acc_t   a2_next, a3_next, b2_next, c2_next;
    acc_t   a2_reg, a3_reg, b2_reg, c2_s1_reg, v1_s1_reg;
    param_t t1_reg;

    // stage 2: first products
    prod_t  pa_next, pd_next;
    prod_t  pa_reg, pd_reg;
    logic   na_reg, nd_reg;
    acc_t   b2_s2_reg, c2_s2_reg, v1_s2_reg;
    param_t t2_reg;

    // stage 3: first Horner sums
    acc_t   q1_next, d1_next;
    acc_t   q1_reg, d1_reg, c2_s3_reg, v1_s3_reg;
    param_t t3_reg;

    // stage 4: second products
    prod_t  pq_next, pe_next;
    prod_t  pq_reg, pe_reg;
    logic   nq_reg, ne_reg;
    acc_t   c2_s4_reg, v1_s4_reg;
    param_t t4_reg;

    // stage 5: second Horner sums
    acc_t   q2_next, d2_next;
    acc_t   q2_reg, d2_reg, v1_s5_reg;
    param_t t5_reg;

    // stage 6: last point product, slope halving
    prod_t  pp_next;
    prod_t  pp_reg;
    logic   np_reg;
    acc_t   sl6_next, sl6_reg, v1_s6_reg;

    // stage 7: final point
    acc_t   pt_next;
    acc_t   pt_reg, sl7_reg;

    always_comb
    begin
        v0e = acc_t'(v0);
        v1e = acc_t'(v1);
        v2e = acc_t'(v2);
        v3e = acc_t'(v3);
        d12 = v1e - v2e;

        a2_next = v3e - v0e + d12 + (d12 <<< 1);
        b2_next = (v0e <<< 1) - (v1e <<< 2) - v1e + (v2e <<< 2) - v3e;
        a3_next = a2_next + (a2_next <<< 1);
        c2_next = v2e - v0e;

        pa_next = prod_t'(mag_of(a2_reg)) * prod_t'(t1_reg);
        pd_next = prod_t'(mag_of(a3_reg)) * prod_t'(t1_reg);

        q1_next = round_mul(pa_reg, na_reg, FRAC_W) + b2_s2_reg;
        d1_next = round_mul(pd_reg, nd_reg, FRAC_W) + (b2_s2_reg <<< 1);

        pq_next = prod_t'(mag_of(q1_reg)) * prod_t'(t3_reg);
        pe_next = prod_t'(mag_of(d1_reg)) * prod_t'(t3_reg);

        q2_next = round_mul(pq_reg, nq_reg, FRAC_W) + c2_s4_reg;
        d2_next = round_mul(pe_reg, ne_reg, FRAC_W) + c2_s4_reg;

        pp_next  = prod_t'(mag_of(q2_reg)) * prod_t'(t5_reg);
        sl6_next = half_round(d2_reg);

        pt_next = round_mul(pp_reg, np_reg, FRAC_W + 1) + v1_s6_reg;
    end

    always_ff @(posedge clk)
    begin
        a2_reg    <= a2_next;
        a3_reg    <= a3_next;
        b2_reg    <= b2_next;
        c2_s1_reg <= c2_next;
        v1_s1_reg <= v1e;
        t1_reg    <= t;

        pa_reg    <= pa_next;
        pd_reg    <= pd_next;
        na_reg    <= a2_reg[ACC_W-1];
        nd_reg    <= a3_reg[ACC_W-1];
        b2_s2_reg <= b2_reg;
        c2_s2_reg <= c2_s1_reg;
        v1_s2_reg <= v1_s1_reg;
        t2_reg    <= t1_reg;

        q1_reg    <= q1_next;
        d1_reg    <= d1_next;
        c2_s3_reg <= c2_s2_reg;
        v1_s3_reg <= v1_s2_reg;
        t3_reg    <= t2_reg;

        pq_reg    <= pq_next;
        pe_reg    <= pe_next;
        nq_reg    <= q1_reg[ACC_W-1];
        ne_reg    <= d1_reg[ACC_W-1];
        c2_s4_reg <= c2_s3_reg;
        v1_s4_reg <= v1_s3_reg;
        t4_reg    <= t3_reg;

        q2_reg    <= q2_next;
        d2_reg    <= d2_next;
        v1_s5_reg <= v1_s4_reg;
        t5_reg    <= t4_reg;

        pp_reg    <= pp_next;
        np_reg    <= q2_reg[ACC_W-1];
        sl6_reg   <= sl6_next;
        v1_s6_reg <= v1_s5_reg;

        pt_reg    <= pt_next;
        sl7_reg   <= sl6_reg;
    end

    assign res.point = pt_reg;
    assign res.slope = sl7_reg;

endmodule

[sv/crse_merge.sv]
module crse_merge (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  crse_pkg::lane_res_t lane_x,
    input  crse_pkg::lane_res_t lane_y,
    output logic                done,
    output crse_pkg::coord_t    point_x,
    output crse_pkg::coord_t    point_y,
    output crse_pkg::coord_t    slope_x,
    output crse_pkg::coord_t    slope_y,
    output logic                clamped
);
    import crse_pkg::*;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // Out of range when the bits above the coordinate sign do not all copy it
    function automatic logic is_over(input acc_t v);
        return (v[ACC_W-1:COORD_W-1] != {(ACC_W-COORD_W+1){1'b0}})
            && (v[ACC_W-1:COORD_W-1] != {(ACC_W-COORD_W+1){1'b1}});
    endfunction

    function automatic coord_t sat(input acc_t v);
        coord_t r;
        if (is_over(v))
            r = v[ACC_W-1] ? COORD_MIN : COORD_MAX;
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

    logic   done_reg;
    coord_t px_reg, py_reg, sx_reg, sy_reg;
    logic   clamped_next, clamped_reg;

    always_comb
    begin
        clamped_next = is_over(lane_x.point) | is_over(lane_y.point)
                     | is_over(lane_x.slope) | is_over(lane_y.slope);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        px_reg      <= sat(lane_x.point);
        py_reg      <= sat(lane_y.point);
        sx_reg      <= sat(lane_x.slope);
        sy_reg      <= sat(lane_y.slope);
        clamped_reg <= clamped_next;
    end

    assign done    = done_reg;
    assign point_x = px_reg;
    assign point_y = py_reg;
    assign slope_x = sx_reg;
    assign slope_y = sy_reg;
    assign clamped = clamped_reg;

endmodule

[sv/crse_checker.sv]
module crse_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input crse_pkg::coord_t p1_x,
    input crse_pkg::coord_t p1_y,
    input crse_pkg::coord_t p2_x,
    input crse_pkg::coord_t p2_y,
    input crse_pkg::param_t t_param,
    input logic             done,
    input crse_pkg::coord_t point_x,
    input crse_pkg::coord_t point_y
);
    import crse_pkg::*;

    // Every accepted word yields a strobe after the fixed latency
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##RESULT_LAT done)
        else $error("no result strobe after accepted word");

    // No strobe without a word accepted at the matching edge
    a_done_caused: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, RESULT_LAT))
        else $error("result strobe without accepted word");

    // s = 0 lands exactly on the segment start
    a_start_point: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && t_param == '0) |-> ##RESULT_LAT
        (point_x == $past(p1_x, RESULT_LAT) && point_y == $past(p1_y, RESULT_LAT)))
        else $error("point at s=0 differs from p1");

    // s >= 1 lands exactly on the segment end
    a_end_point: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && t_param[FRAC_W]) |-> ##RESULT_LAT
        (point_x == $past(p2_x, RESULT_LAT) && point_y == $past(p2_y, RESULT_LAT)))
        else $error("point at s=1 differs from p2");

endmodule

bind catmull_rom_spline_eval crse_checker u_crse_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .p1_x    (p1_x),
    .p1_y    (p1_y),
    .p2_x    (p2_x),
    .p2_y    (p2_y),
    .t_param (t_param),
    .done    (done),
    .point_x (point_x),
    .point_y (point_y)
);

[tb/sv/spline_eval_checker.sv]
`timescale 1ns / 100ps

module spline_eval_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  crse_pkg::coord_t p0_x,
    input  crse_pkg::coord_t p0_y,
    input  crse_pkg::coord_t p1_x,
    input  crse_pkg::coord_t p1_y,
    input  crse_pkg::coord_t p2_x,
    input  crse_pkg::coord_t p2_y,
    input  crse_pkg::coord_t p3_x,
    input  crse_pkg::coord_t p3_y,
    input  crse_pkg::param_t t_param,
    input  logic             done,
    input  crse_pkg::coord_t point_x,
    input  crse_pkg::coord_t point_y,
    input  crse_pkg::coord_t slope_x,
    input  crse_pkg::coord_t slope_y,
    input  logic             clamped,
    output int               errors,
    output int               pending
);

    import crse_pkg::*;

    localparam longint COORD_HI = (64'sd1 <<< (COORD_W - 1)) - 64'sd1;
    localparam longint COORD_LO = -(64'sd1 <<< (COORD_W - 1));

    typedef struct packed {
        coord_t px;
        coord_t py;
        coord_t sx;
        coord_t sy;
        logic   clip;
    } spline_word_t;

    typedef struct packed {
        longint pos;
        longint rate;
    } axis_val_t;

    spline_word_t expected_words[$];
    int           mismatch_count = 0;

    assign errors = mismatch_count;

    // x * t / 2^sh, rounded to nearest with ties away from zero
    function automatic longint scale_round(input longint x, input longint t, input int sh);
        longint m;
        m = (x < 0) ? -x : x;
        m = (m * t + (64'sd1 <<< (sh - 1))) >>> sh;
        return (x < 0) ? -m : m;
    endfunction

    function automatic axis_val_t eval_axis(input longint v0, input longint v1,
                                            input longint v2, input longint v3,
                                            input longint t);
        longint    a2;
        longint    b2;
        longint    c2;
        longint    q;
        longint    m;
        axis_val_t r;
        a2 = -v0 + 3 * v1 - 3 * v2 + v3;
        b2 = 2 * v0 - 5 * v1 + 4 * v2 - v3;
        c2 = v2 - v0;
        q = scale_round(a2, t, FRAC_W) + b2;
        q = scale_round(q, t, FRAC_W) + c2;
        r.pos = scale_round(q, t, FRAC_W + 1) + v1;
        q = scale_round(3 * a2, t, FRAC_W) + 2 * b2;
        q = scale_round(q, t, FRAC_W) + c2;
        m = (q < 0) ? -q : q;
        m = (m + 1) >>> 1;
        r.rate = (q < 0) ? -m : m;
        return r;
    endfunction

    function automatic coord_t clip_coord(input longint v, inout logic hit);
        if (v > COORD_HI)
        begin
            v = COORD_HI;
            hit = 1'b1;
        end
        if (v < COORD_LO)
        begin
            v = COORD_LO;
            hit = 1'b1;
        end
        return coord_t'(v);
    endfunction

    function automatic spline_word_t predict_spline();
        longint       t;
        axis_val_t    ax;
        axis_val_t    ay;
        spline_word_t w;
        logic         hit;
        t = longint'(t_param);
        if (t > longint'(PARAM_ONE))
            t = longint'(PARAM_ONE);
        ax = eval_axis(longint'(p0_x), longint'(p1_x), longint'(p2_x), longint'(p3_x), t);
        ay = eval_axis(longint'(p0_y), longint'(p1_y), longint'(p2_y), longint'(p3_y), t);
        hit = 1'b0;
        w.px = clip_coord(ax.pos, hit);
        w.py = clip_coord(ay.pos, hit);
        w.sx = clip_coord(ax.rate, hit);
        w.sy = clip_coord(ay.rate, hit);
        w.clip = hit;
        return w;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        if (mismatch_count < 40)
            $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        spline_word_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_words.size() == 0)
                    report("result with no word pending", 0, 0);
                else
                begin
                    want = expected_words.pop_front();
                    if (point_x !== want.px)
                        report("point_x", longint'(point_x), longint'(want.px));
                    if (point_y !== want.py)
                        report("point_y", longint'(point_y), longint'(want.py));
                    if (slope_x !== want.sx)
                        report("slope_x", longint'(slope_x), longint'(want.sx));
                    if (slope_y !== want.sy)
                        report("slope_y", longint'(slope_y), longint'(want.sy));
                    if (clamped !== want.clip)
                        report("clamped", longint'(clamped), longint'(want.clip));
                end
            end
            if (start && !busy)
                expected_words.push_back(predict_spline());
        end
        pending <= expected_words.size();
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;

    import crse_pkg::*;

    // Cycles with neither an accepted word nor a result before the run is called hung.
    // The longest correct quiet stretch is a long sender gap plus the block latency.
    localparam int IDLE_LIMIT   = 500;
    localparam int RANDOM_WORDS = 750;

    localparam coord_t C_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
    localparam coord_t C_MIN = {1'b1, {(COORD_W - 1){1'b0}}};
    localparam coord_t C_ONE = coord_t'(1) <<< FRAC_W;

    typedef struct packed {
        coord_t x0;
        coord_t y0;
        coord_t x1;
        coord_t y1;
        coord_t x2;
        coord_t y2;
        coord_t x3;
        coord_t y3;
        param_t t;
    } ctrl_word_t;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   start;
    logic   busy;
    coord_t p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y;
    param_t t_param;
    logic   done;
    coord_t point_x, point_y, slope_x, slope_y;
    logic   clamped;
    int     errors;
    int     pending;
    int     idle_cycles = 0;

    always #4 clk = ~clk;

    catmull_rom_spline_eval dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .p0_x    (p0_x),
        .p0_y    (p0_y),
        .p1_x    (p1_x),
        .p1_y    (p1_y),
        .p2_x    (p2_x),
        .p2_y    (p2_y),
        .p3_x    (p3_x),
        .p3_y    (p3_y),
        .t_param (t_param),
        .done    (done),
        .point_x (point_x),
        .point_y (point_y),
        .slope_x (slope_x),
        .slope_y (slope_y),
        .clamped (clamped)
    );

    // The checker sees the same pins as the block; it owns prediction and comparison.
    spline_eval_checker chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .p0_x    (p0_x),
        .p0_y    (p0_y),
        .p1_x    (p1_x),
        .p1_y    (p1_y),
        .p2_x    (p2_x),
        .p2_y    (p2_y),
        .p3_x    (p3_x),
        .p3_y    (p3_y),
        .t_param (t_param),
        .done    (done),
        .point_x (point_x),
        .point_y (point_y),
        .slope_x (slope_x),
        .slope_y (slope_y),
        .clamped (clamped),
        .errors  (errors),
        .pending (pending)
    );

    // Watchdog: restart the count on every accepted word or result strobe.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[catmull_rom_spline_eval] ERROR");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic ctrl_word_t make_word(input coord_t x0, input coord_t y0,
                                             input coord_t x1, input coord_t y1,
                                             input coord_t x2, input coord_t y2,
                                             input coord_t x3, input coord_t y3,
                                             input param_t t);
        ctrl_word_t w;
        w = {x0, y0, x1, y1, x2, y2, x3, y3, t};
        return w;
    endfunction

    // Present one word and hold it until the block takes it. Only drop start when a
    // gap is wanted, so back-to-back words keep start high without a glitch.
    task automatic drive_word(input ctrl_word_t w, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        p0_x    <= w.x0;
        p0_y    <= w.y0;
        p1_x    <= w.x1;
        p1_y    <= w.y1;
        p2_x    <= w.x2;
        p2_y    <= w.y2;
        p3_x    <= w.x3;
        p3_y    <= w.y3;
        t_param <= w.t;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Mostly short gaps, a few long ones that let the pipeline drain completely.
    function automatic int pick_gap(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic param_t pick_param();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 5))
                    0: return '0;
                    1: return param_t'(1);
                    2: return PARAM_ONE - param_t'(1);
                    3: return PARAM_ONE;
                    4: return PARAM_ONE + param_t'(1);
                    default: return '1;
                endcase
            end
            // above one: the block saturates to s = 1
            1: return param_t'($urandom_range(32'h1_0001, 32'h1_FFFF));
            default: return param_t'($urandom_range(0, 32'h1_0000));
        endcase
    endfunction

    function automatic coord_t pick_extreme();
        case ($urandom_range(0, 5))
            0: return C_MAX;
            1: return C_MIN;
            2: return '0;
            3: return '1;
            4: return coord_t'(1);
            default: return $urandom_range(0, 1) ? C_ONE : -C_ONE;
        endcase
    endfunction

    // Random control points: mostly smooth nearby points as a path generator would
    // produce, then full-range noise, extremes and large values that push clamping.
    function automatic ctrl_word_t pick_word();
        ctrl_word_t w;
        coord_t     bx;
        coord_t     by;
        int         mode;
        int         span;
        mode = $urandom_range(0, 9);
        w.t  = pick_param();
        if (mode <= 5)
        begin
            bx   = coord_t'($urandom_range(0, 32'h01FF_FFFF)) - coord_t'(32'h0100_0000);
            by   = coord_t'($urandom_range(0, 32'h01FF_FFFF)) - coord_t'(32'h0100_0000);
            span = $urandom_range(4, 22);
            w.x0 = bx + coord_t'($urandom_range(0, (1 << span) - 1)) - coord_t'(1 << (span - 1));
            w.y0 = by + coord_t'($urandom_range(0, (1 << span) - 1)) - coord_t'(1 << (span - 1));
            w.x1 = bx + coord_t'($urandom_range(0, (1 << span) - 1)) - coord_t'(1 << (span - 1));
            w.y1 = by + coord_t'($urandom_range(0, (1 << span) - 1)) - coord_t'(1 << (span - 1));
            w.x2 = bx + coord_t'($urandom_range(0, (1 << span) - 1)) - coord_t'(1 << (span - 1));
            w.y2 = by + coord_t'($urandom_range(0, (1 << span) - 1)) - coord_t'(1 << (span - 1));
            w.x3 = bx + coord_t'($urandom_range(0, (1 << span) - 1)) - coord_t'(1 << (span - 1));
            w.y3 = by + coord_t'($urandom_range(0, (1 << span) - 1)) - coord_t'(1 << (span - 1));
        end
        else if (mode <= 7)
        begin
            w.x0 = $urandom;
            w.y0 = $urandom;
            w.x1 = $urandom;
            w.y1 = $urandom;
            w.x2 = $urandom;
            w.y2 = $urandom;
            w.x3 = $urandom;
            w.y3 = $urandom;
        end
        else if (mode == 8)
        begin
            w.x0 = pick_extreme();
            w.y0 = pick_extreme();
            w.x1 = pick_extreme();
            w.y1 = pick_extreme();
            w.x2 = pick_extreme();
            w.y2 = pick_extreme();
            w.x3 = pick_extreme();
            w.y3 = pick_extreme();
        end
        else
        begin
            // large alternating magnitudes: overshoot near the range edges
            w.x0 = $urandom_range(0, 1) ? C_MIN + coord_t'($urandom_range(0, 32'h0FFF_FFFF))
                                        : C_MAX - coord_t'($urandom_range(0, 32'h0FFF_FFFF));
            w.y0 = -w.x0;
            w.x1 = -w.x0 + coord_t'($urandom_range(0, 32'h00FF_FFFF));
            w.y1 = w.x0 ^ coord_t'($urandom_range(0, 32'h00FF_FFFF));
            w.x2 = w.x0 + coord_t'($urandom_range(0, 32'h00FF_FFFF));
            w.y2 = $urandom;
            w.x3 = -w.x1;
            w.y3 = pick_extreme();
        end
        return w;
    endfunction

    initial
    begin
        ctrl_word_t directed_words[$];
        bit         burst;

        // Hold every input at a known value through reset.
        rst_n   <= 1'b0;
        start   <= 1'b0;
        p0_x    <= '0;
        p0_y    <= '0;
        p1_x    <= '0;
        p1_y    <= '0;
        p2_x    <= '0;
        p2_y    <= '0;
        p3_x    <= '0;
        p3_y    <= '0;
        t_param <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: parameter ends and the saturation of s above one.
        directed_words.push_back(make_word('0, '0, '0, '0, '0, '0, '0, '0, '0));
        directed_words.push_back(make_word('0, '0, C_ONE, C_ONE, 2 * C_ONE, 2 * C_ONE,
                                           3 * C_ONE, 3 * C_ONE, '0));
        directed_words.push_back(make_word('0, '0, C_ONE, C_ONE, 2 * C_ONE, 2 * C_ONE,
                                           3 * C_ONE, 3 * C_ONE, PARAM_ONE >> 1));
        directed_words.push_back(make_word('0, '0, C_ONE, -C_ONE, 2 * C_ONE, 5 * C_ONE,
                                           -C_ONE, 3 * C_ONE, PARAM_ONE));
        directed_words.push_back(make_word('0, '0, C_ONE, -C_ONE, 2 * C_ONE, 5 * C_ONE,
                                           -C_ONE, 3 * C_ONE, PARAM_ONE + param_t'(1)));
        directed_words.push_back(make_word(C_ONE, 7, -3, C_ONE, 11, -C_ONE, 5, 9, '1));
        directed_words.push_back(make_word(C_ONE, 7, -3, C_ONE, 11, -C_ONE, 5, 9,
                                           param_t'(1)));
        directed_words.push_back(make_word(C_ONE, 7, -3, C_ONE, 11, -C_ONE, 5, 9,
                                           PARAM_ONE - param_t'(1)));
        // Directed: coordinate extremes, and overshoot that clamps in both directions.
        directed_words.push_back(make_word(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                                           C_MAX, C_MAX, PARAM_ONE >> 1));
        directed_words.push_back(make_word(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                                           C_MIN, C_MIN, PARAM_ONE >> 1));
        directed_words.push_back(make_word(C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX,
                                           C_MAX, C_MIN, PARAM_ONE >> 1));
        directed_words.push_back(make_word(C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX,
                                           C_MAX, C_MIN, param_t'(16384)));
        // slope at s = 0 is (p2 - p0) / 2: full-scale span clamps it
        directed_words.push_back(make_word(C_MIN, C_MAX, '0, '0, C_MAX, C_MIN,
                                           '0, '0, '0));
        directed_words.push_back(make_word(C_MIN, C_MAX, '0, '0, C_MAX, C_MIN,
                                           '0, '0, PARAM_ONE));
        // Directed: rounding ties on the halved slope, all ones, lone LSBs.
        directed_words.push_back(make_word('0, '0, '0, '0, coord_t'(1), -coord_t'(1),
                                           '0, '0, '0));
        directed_words.push_back(make_word('1, '1, '1, '1, '1, '1, '1, '1, '1));
        directed_words.push_back(make_word(coord_t'(1), -coord_t'(3), coord_t'(5),
                                           coord_t'(2), -coord_t'(7), coord_t'(1),
                                           coord_t'(3), -coord_t'(1), param_t'(3)));
        directed_words.push_back(make_word(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN,
                                           C_MIN, C_MAX, PARAM_ONE));

        foreach (directed_words[i])
            drive_word(directed_words[i], (i % 4 == 3) ? 2 : 0);

        // Random: switch between no-idle stretches and gappy stretches now and then.
        burst = 1'b0;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if ($urandom_range(0, 39) == 0)
                burst = ~burst;
            drive_word(pick_word(), pick_gap(burst));
        end
        start <= 1'b0;

        // Drain: wait for every predicted word, then for the pipeline depth.
        while (pending != 0)
            @(posedge clk);
        repeat (RESULT_LAT + 4) @(posedge clk);

        if (errors == 0)
            $display("[catmull_rom_spline_eval] OK");
        else
            $display("[catmull_rom_spline_eval] ERROR");
        $finish;
    end

endmodule

[filelist.f]
sv/crse_pkg.sv
sv/crse_lane.sv
sv/crse_merge.sv
sv/catmull_rom_spline_eval.sv
sv/crse_checker.sv
tb/sv/spline_eval_checker.sv
tb/sv/tb.sv
